/* src/rsm_pkg.sv */
`default_nettype none
package rsm_pkg;

  localparam int WordW  = 32;
  localparam int CmdW   = 4;
  localparam int StatW  = 3;
  localparam int DepthW = 5;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [CmdW-1:0]   cmd_t;
  typedef logic [StatW-1:0]  stat_t;
  typedef logic [DepthW-1:0] depth_t;

  localparam cmd_t CMD_ADD   = 4'd0;
  localparam cmd_t CMD_SUB   = 4'd1;
  localparam cmd_t CMD_MUL   = 4'd2;
  localparam cmd_t CMD_DIV   = 4'd3;
  localparam cmd_t CMD_SHL   = 4'd4;
  localparam cmd_t CMD_SHR   = 4'd5;
  localparam cmd_t CMD_PUSH  = 4'd6;
  localparam cmd_t CMD_PRINT = 4'd7;
  localparam cmd_t CMD_END   = 4'd8;
  localparam cmd_t CMD_NOP   = 4'd9;

  localparam stat_t ST_OK      = 3'd0;
  localparam stat_t ST_UNDER   = 3'd1;
  localparam stat_t ST_OVER    = 3'd2;
  localparam stat_t ST_DIVZERO = 3'd3;
  localparam stat_t ST_SKIP    = 3'd4;

  // request from the sequencer to the serial arithmetic unit
  typedef struct packed {
    logic start;
    cmd_t op;
  } alu_req_t;

endpackage
`default_nettype wire

/* src/rsm_if.sv */
`default_nettype none
interface rsm_in_if import rsm_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t literal;
  logic  program_start;

  modport source (output valid, command, literal, program_start, input ready);
  modport sink   (input valid, command, literal, program_start, output ready);
endinterface

interface rsm_out_if import rsm_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   print_valid;
  word_t  print_value;
  stat_t  status;
  depth_t stack_depth;

  modport source (output valid, print_valid, print_value, status, stack_depth, input ready);
  modport sink   (input valid, print_valid, print_value, status, stack_depth, output ready);
endinterface
`default_nettype wire

/* src/rsm_alu.sv */
`default_nettype none
// Serial arithmetic unit: one bit of the operation per cycle, 32 steps.
module rsm_alu import rsm_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  alu_req_t  req,
  input  word_t     a,
  input  word_t     b,
  output logic      done,
  output word_t     result
);

  localparam int CntW = $clog2(WordW);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  cmd_t            op_r, op_nxt;
  word_t           x_r, x_nxt;
  word_t           y_r, y_nxt;
  word_t           acc_r, acc_nxt;
  logic            carry_r, carry_nxt;

  logic            yb;
  logic            sbit;
  logic [WordW:0]  rem;
  logic [WordW:0]  diff;
  logic            ge;
  logic            wide_shift;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;

    yb   = y_r[0] ^ (op_r == CMD_SUB);
    sbit = x_r[0] ^ yb ^ carry_r;
    rem  = {acc_r, x_r[WordW-1]};
    diff = rem - {1'b0, y_r};
    ge   = (rem >= {1'b0, y_r});
    wide_shift = |b[WordW-1:CntW];

    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      op_nxt    = req.op;
      // shift by 32 or more: shifting a zero word gives the result
      x_nxt     = ((req.op == CMD_SHL || req.op == CMD_SHR) && wide_shift) ? '0 : a;
      y_nxt     = b;
      acc_nxt   = '0;
      carry_nxt = (req.op == CMD_SUB);
    end else if (busy_r) begin
      case (op_r)
        CMD_ADD, CMD_SUB: begin
          acc_nxt   = {sbit, acc_r[WordW-1:1]};
          carry_nxt = (x_r[0] & yb) | (x_r[0] & carry_r) | (yb & carry_r);
          x_nxt     = x_r >> 1;
          y_nxt     = y_r >> 1;
        end
        CMD_MUL: begin
          if (y_r[0]) acc_nxt = acc_r + x_r;
          x_nxt = x_r << 1;
          y_nxt = y_r >> 1;
        end
        CMD_DIV: begin
          acc_nxt = ge ? diff[WordW-1:0] : rem[WordW-1:0];
          x_nxt   = {x_r[WordW-2:0], ge};
        end
        CMD_SHL: begin
          if (cnt_r < y_r[CntW-1:0]) x_nxt = x_r << 1;
        end
        CMD_SHR: begin
          if (cnt_r < y_r[CntW-1:0]) x_nxt = x_r >> 1;
        end
        default: ;
      endcase
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(WordW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= CMD_NOP;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    acc_r   <= acc_nxt;
    carry_r <= carry_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == CMD_ADD || op_r == CMD_SUB || op_r == CMD_MUL) ? acc_r : x_r;

endmodule
`default_nettype wire

/* src/rsm_stack.sv */
`default_nettype none
// Stack storage: one write port, one registered read port.
module rsm_stack import rsm_pkg::*; #(
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire              clk,
  input  wire              we,
  input  wire  [AddrW-1:0] waddr,
  input  word_t            wdata,
  input  wire              re,
  input  wire  [AddrW-1:0] raddr,
  output word_t            rdata
);

  word_t mem [Depth];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/rpn_stack_machine_core.sv */
`default_nettype none
// Channel  Dir  Interface           Payload
// in_ch    in   rsm_in_if.sink      command, literal, program_start
// out_ch   out  rsm_out_if.source   print_valid, print_value, status, stack_depth
//
// Arithmetic (add, sub, mul, div, shl, shr): decode, two stack reads, serial unit and
// output load before the next transaction. Push, end, nop, skipped, underflow, overflow:
// decode and output load; print adds a stack read; divide by zero stops after both reads.
// Reset clears the stack pointer, the halt flag and out_ch.valid; stack words are
// not cleared and are only read after being pushed.
// A finished result waits in the output register while a new transaction is taken.
module rpn_stack_machine_core import rsm_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  rsm_in_if.sink     in_ch,
  rsm_out_if.source  out_ch
);

  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam int SpW   = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;  // decode, first stack read
  localparam logic [2:0] S_RDB  = 3'd2;  // capture a, read b
  localparam logic [2:0] S_LDB  = 3'd3;  // capture b, start serial unit
  localparam logic [2:0] S_EXEC = 3'd4;  // wait for serial unit, write back
  localparam logic [2:0] S_PRT  = 3'd5;  // capture printed word
  localparam logic [2:0] S_OUT  = 3'd6;  // hand result to output register

  logic [2:0]     state_r, state_nxt;
  logic [SpW-1:0] sp_r, sp_nxt;
  logic           halted_r, halted_nxt;

  cmd_t  cmd_r;
  word_t lit_r;
  logic  start_r;
  word_t a_r, a_nxt;

  // pending result
  logic  pv_r, pv_nxt;
  word_t pval_r, pval_nxt;
  stat_t st_r, st_nxt;

  // output register
  logic   ov_r, ov_nxt;
  logic   opv_r;
  word_t  opval_r;
  stat_t  ost_r;
  depth_t odep_r;

  logic             in_acc;
  logic             out_load;
  logic             halted_eff;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  word_t            mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  word_t            mem_rdata;

  alu_req_t         alu_req;
  logic             alu_done;
  word_t            alu_res;

  logic [AddrW-1:0] top_addr;
  logic [AddrW-1:0] next_addr;
  logic [AddrW-1:0] push_addr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_OUT) && (!ov_r || out_ch.ready);

  assign top_addr   = AddrW'(sp_r - SpW'(1));
  assign next_addr  = AddrW'(sp_r - SpW'(2));
  assign push_addr  = AddrW'(sp_r);
  assign halted_eff = halted_r && !start_r;

  rsm_stack #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rsm_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (a_r),
    .b      (mem_rdata),
    .done   (alu_done),
    .result (alu_res)
  );

  always_comb begin
    state_nxt  = state_r;
    sp_nxt     = sp_r;
    halted_nxt = halted_r;
    a_nxt      = a_r;
    pv_nxt     = pv_r;
    pval_nxt   = pval_r;
    st_nxt     = st_r;

    mem_we    = 1'b0;
    mem_waddr = push_addr;
    mem_wdata = lit_r;
    mem_re    = 1'b0;
    mem_raddr = top_addr;

    alu_req.start = 1'b0;
    alu_req.op    = cmd_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pv_nxt    = 1'b0;
          pval_nxt  = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        halted_nxt = halted_eff;
        state_nxt  = S_OUT;
        if (halted_eff) begin
          st_nxt = ST_SKIP;
        end else begin
          case (cmd_r)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SHL, CMD_SHR: begin
              if (sp_r < SpW'(2)) begin
                st_nxt = ST_UNDER;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_RDB;
              end
            end
            CMD_PUSH: begin
              if (sp_r >= SpW'(STACK_DEPTH)) begin
                st_nxt = ST_OVER;
              end else begin
                mem_we = 1'b1;
                sp_nxt = sp_r + SpW'(1);
              end
            end
            CMD_PRINT: begin
              if (sp_r == '0) begin
                st_nxt = ST_UNDER;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_PRT;
              end
            end
            CMD_END: halted_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      S_RDB: begin
        a_nxt     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = next_addr;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        if (cmd_r == CMD_DIV && mem_rdata == '0) begin
          st_nxt    = ST_DIVZERO;
          state_nxt = S_OUT;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          mem_we    = 1'b1;
          mem_waddr = next_addr;
          mem_wdata = alu_res;
          sp_nxt    = sp_r - SpW'(1);
          state_nxt = S_OUT;
        end
      end
      S_PRT: begin
        pv_nxt    = 1'b1;
        pval_nxt  = mem_rdata;
        sp_nxt    = sp_r - SpW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ch.ready) ov_nxt = 1'b0;
    if (out_load)     ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sp_r     <= '0;
      halted_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      halted_r <= halted_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_ch.command;
      lit_r   <= in_ch.literal;
      start_r <= in_ch.program_start;
    end
    a_r    <= a_nxt;
    pv_r   <= pv_nxt;
    pval_r <= pval_nxt;
    st_r   <= st_nxt;
    if (out_load) begin
      opv_r   <= pv_r;
      opval_r <= pval_r;
      ost_r   <= st_r;
      odep_r  <= DepthW'(sp_r);
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.print_valid = opv_r;
  assign out_ch.print_value = opval_r;
  assign out_ch.status      = ost_r;
  assign out_ch.stack_depth = odep_r;

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
  import rsm_pkg::*;

  localparam int StackDepth    = 16;
  localparam int WatchdogLimit = 2000;  // cycles with no transaction on either side
  localparam int HoldCycles    = 250;   // long receiver hold-off
  localparam int DrainCycles   = 40;    // settle time after the last result
  localparam cmd_t CmdMax      = '1;    // codes above CMD_NOP decode as nop

  // one instruction as presented on in_ch
  typedef struct packed {
    cmd_t  command;
    word_t literal;
    logic  program_start;
  } instr_t;

  // one result as seen on out_ch
  typedef struct packed {
    logic   print_valid;
    word_t  print_value;
    stat_t  status;
    depth_t stack_depth;
  } calc_res_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  rsm_in_if  in_ch ();
  rsm_out_if out_ch ();

  rpn_stack_machine_core #(.STACK_DEPTH(StackDepth)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the calculator state, advanced once per accepted
  // instruction. Only entries below calc_sp are ever read.
  // ---------------------------------------------------------------------------
  word_t calc_stack [StackDepth];
  int    calc_sp;
  logic  calc_halted;

  function automatic calc_res_t exec_instr(instr_t ins);
    calc_res_t res;
    word_t     a;
    word_t     b;
    word_t     r;
    res = '{print_valid: 1'b0, print_value: '0, status: ST_OK, stack_depth: '0};
    r   = '0;
    // a program start clears the halt before its own instruction runs
    if (ins.program_start) calc_halted = 1'b0;
    if (calc_halted) begin
      res.status = ST_SKIP;
    end else if (ins.command <= CMD_SHR) begin
      if (calc_sp < 2) begin
        res.status = ST_UNDER;
      end else begin
        a = calc_stack[calc_sp-1];   // top
        b = calc_stack[calc_sp-2];   // next
        case (ins.command)
          CMD_ADD: r = a + b;
          CMD_SUB: r = a - b;
          CMD_MUL: r = a * b;        // low 32 bits of the product
          CMD_DIV: begin
            if (b == '0) res.status = ST_DIVZERO;
            else r = a / b;
          end
          CMD_SHL: r = (b >= 32) ? '0 : (a << b);
          default: r = (b >= 32) ? '0 : (a >> b);
        endcase
        // any error leaves the stack as it was
        if (res.status == ST_OK) begin
          calc_sp--;
          calc_stack[calc_sp-1] = r;
        end
      end
    end else if (ins.command == CMD_PUSH) begin
      if (calc_sp >= StackDepth) begin
        res.status = ST_OVER;
      end else begin
        calc_stack[calc_sp] = ins.literal;
        calc_sp++;
      end
    end else if (ins.command == CMD_PRINT) begin
      if (calc_sp == 0) begin
        res.status = ST_UNDER;
      end else begin
        calc_sp--;
        res.print_value = calc_stack[calc_sp];
        res.print_valid = 1'b1;
      end
    end else if (ins.command == CMD_END) begin
      calc_halted = 1'b1;
    end
    // codes CMD_NOP and above fall through with no effect
    res.stack_depth = depth_t'(calc_sp);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: both handshakes are sampled at the same edge in one process, so
  // the prediction of a transaction is always queued before its result is seen.
  // ---------------------------------------------------------------------------
  calc_res_t pending_results[$];
  int        outstanding;         // results still owed, updated by nonblocking assignment
  int        idle_cycles;
  int        n_errors;
  int        n_checked;
  int        n_prints;
  int        status_cnt [5];

  task automatic flag_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= 30)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  task automatic check_result(calc_res_t got);
    calc_res_t want;
    if (pending_results.size() == 0) begin
      n_errors++;
      $display("%0t: unexpected result: expected none, got %p", $time, got);
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    if (want.print_valid) n_prints++;
    if (int'(want.status) < 5) status_cnt[int'(want.status)]++;
    flag_field("print_valid", 32'(want.print_valid), 32'(got.print_valid));
    flag_field("print_value", want.print_value, got.print_value);
    flag_field("status", 32'(want.status), 32'(got.status));
    flag_field("stack_depth", 32'(want.stack_depth), 32'(got.stack_depth));
  endtask

  always @(posedge clk) begin : scoreboard
    logic   in_acc;
    logic   out_acc;
    instr_t ins;
    in_acc  = in_ch.valid && in_ch.ready;
    out_acc = out_ch.valid && out_ch.ready;
    if (!rst_n) begin
      calc_sp     = 0;
      calc_halted = 1'b0;
      outstanding <= 0;
      idle_cycles <= 0;
    end else begin
      if (in_acc) begin
        ins = '{command: in_ch.command, literal: in_ch.literal,
                program_start: in_ch.program_start};
        pending_results.push_back(exec_instr(ins));
      end
      if (out_acc)
        check_result('{print_valid: out_ch.print_valid, print_value: out_ch.print_value,
                       status: out_ch.status, stack_depth: out_ch.stack_depth});
      outstanding <= outstanding + int'(in_acc) - int'(out_acc);
      // watchdog: any transaction restarts the count
      if (in_acc || out_acc) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: timeout, no transaction for %0d cycles, %0d results owed",
                 $time, idle_cycles, outstanding);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request from a test
  // (hold_req bumped by one per request).
  // ---------------------------------------------------------------------------
  int sink_stall_pct;
  int hold_req;

  initial begin : receiver
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int src_gap_pct;
  int n_sent;
  int gen_depth;   // rough stack depth seen by the program generator

  // Offer one instruction and hold it until the block takes it. Called at a
  // rising edge; returns at the edge where the transaction completed. valid is
  // only lowered when a gap actually starts.
  task automatic send_instr(cmd_t c, word_t lit, logic start);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_gap_pct) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= c;
    in_ch.literal       <= lit;
    in_ch.program_start <= start;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_sent++;
  endtask

  // sender pauses until every owed result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // literal mix: small values reach the shift and divide corners
  function automatic word_t rand_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return word_t'($urandom_range(0, 40));
    if (pick < 45) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h7fff_ffff;
        3: return 32'h8000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return word_t'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked corners; comments track the stack, top on the right.
  task automatic test_directed();
    src_gap_pct    <= 20;
    sink_stall_pct <= 20;
    send_instr(CMD_PRINT, 32'hffff_ffff, 1'b1);   // print on empty stack
    send_instr(CMD_ADD,   '0, 1'b0);              // binary op on empty stack
    send_instr(CMD_PUSH,  32'hffff_ffff, 1'b0);   // [F]
    send_instr(CMD_SUB,   '0, 1'b0);              // only one word
    send_instr(CMD_PUSH,  32'h0000_0001, 1'b0);   // [F 1]
    send_instr(CMD_ADD,   '0, 1'b0);              // wraps to 0: [0]
    send_instr(CMD_PUSH,  32'd9, 1'b0);           // [0 9]
    send_instr(CMD_DIV,   '0, 1'b0);              // divide by zero, stack kept
    send_instr(CMD_PUSH,  32'hffff_ffff, 1'b0);   // [0 9 F]
    send_instr(CMD_MUL,   '0, 1'b0);              // [0 FFFFFFF7]
    send_instr(CMD_PUSH,  32'd32, 1'b0);          // shift count of 32
    send_instr(CMD_PUSH,  32'hffff_ffff, 1'b0);
    send_instr(CMD_SHL,   '0, 1'b0);              // wide shift gives 0
    send_instr(CMD_PUSH,  32'd31, 1'b0);
    send_instr(CMD_PUSH,  32'h8000_0000, 1'b0);
    send_instr(CMD_SHR,   '0, 1'b0);              // 1
    send_instr(CMD_PRINT, '0, 1'b0);              // prints 1: [0 FFFFFFF7 0]
    send_instr(CMD_END,   '0, 1'b0);
    send_instr(CMD_PUSH,  32'd5, 1'b0);           // skipped while halted
    send_instr(CMD_ADD,   '0, 1'b0);              // skipped
    send_instr(CmdMax,    32'hffff_ffff, 1'b1);   // unknown code on a new program
    send_instr(cmd_t'(int'(CMD_NOP) + 1), '0, 1'b0);
    send_instr(CMD_NOP,   '0, 1'b0);
    send_instr(CMD_DIV,   '0, 1'b0);              // 0 / FFFFFFF7 = 0
    send_instr(CMD_PRINT, '0, 1'b0);
    gen_depth = 1;
    wait_drained();
  endtask

  // Fill to full, push past it, then reduce and print down into underflow.
  task automatic test_stack_limits();
    int pushes;
    src_gap_pct    <= 10;
    sink_stall_pct <= 10;
    repeat (3) begin
      pushes = StackDepth + $urandom_range(1, 3);
      for (int i = 0; i < pushes; i++) send_instr(CMD_PUSH, rand_word(), i == 0);
      repeat (StackDepth + 1)
        send_instr(cmd_t'($urandom_range(CMD_ADD, CMD_SHR)), word_t'($urandom), 1'b0);
      repeat (3) send_instr(CMD_PRINT, word_t'($urandom), 1'b0);
    end
    gen_depth = 0;
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering back to back, so the
  // block fills up and must stall in_ch; then the sender waits for a full drain.
  task automatic test_backpressure();
    src_gap_pct    <= 0;
    sink_stall_pct <= 0;
    hold_req       <= hold_req + 1;
    for (int i = 0; i < 8; i++) begin
      send_instr(CMD_PUSH, rand_word(), i == 0);
      send_instr(CMD_PUSH, rand_word(), 1'b0);
      send_instr(cmd_t'($urandom_range(CMD_ADD, CMD_SHR)), word_t'($urandom), 1'b0);
    end
    wait_drained();
  endtask

  // One well-formed program with random content, then usually END and some
  // trailing instructions that must be skipped.
  task automatic run_program(int len);
    int    pick;
    cmd_t  c;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if ((gen_depth < 2 && pick < 70) || pick < 35 || pick >= 95)
        c = CMD_PUSH;
      else if (gen_depth >= 14 || pick < 75)
        c = cmd_t'($urandom_range(CMD_ADD, CMD_SHR));
      else if (pick < 88)
        c = CMD_PRINT;
      else
        c = cmd_t'($urandom_range(CMD_NOP, CmdMax));
      send_instr(c, (c == CMD_PUSH) ? rand_word() : word_t'($urandom), i == 0);
      if (c == CMD_PUSH && gen_depth < StackDepth) gen_depth++;
      else if (c <= CMD_SHR && gen_depth >= 2) gen_depth--;
      else if (c == CMD_PRINT && gen_depth > 0) gen_depth--;
    end
    if ($urandom_range(0, 99) < 85) begin
      send_instr(CMD_END, word_t'($urandom), 1'b0);
      repeat ($urandom_range(0, 3))
        send_instr(cmd_t'($urandom_range(0, CmdMax)), word_t'($urandom), 1'b0);
    end
  endtask

  task automatic test_random_programs(int n_items, bit idling);
    int done;
    int len;
    done = 0;
    while (done < n_items) begin
      if (idling) begin
        // per program: sometimes no idling at all, sometimes heavy
        case ($urandom_range(0, 4))
          0, 1: src_gap_pct <= 0;
          2: src_gap_pct <= 10;
          3: src_gap_pct <= 25;
          default: src_gap_pct <= 50;
        endcase
        case ($urandom_range(0, 4))
          0, 1: sink_stall_pct <= 0;
          2: sink_stall_pct <= 10;
          3: sink_stall_pct <= 25;
          default: sink_stall_pct <= 50;
        endcase
      end else begin
        src_gap_pct    <= 0;
        sink_stall_pct <= 0;
      end
      len = $urandom_range(1, 30);
      run_program(len);
      done += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_NOP;
    in_ch.literal       <= '0;
    in_ch.program_start <= 1'b0;
    src_gap_pct         <= 0;
    sink_stall_pct      <= 0;
    hold_req            <= 0;
    n_errors  = 0;
    n_checked = 0;
    n_prints  = 0;
    n_sent    = 0;
    gen_depth = 0;
    foreach (status_cnt[i]) status_cnt[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_stack_limits();
    test_backpressure();
    test_random_programs(500, 1'b1);
    test_random_programs(100, 1'b0);   // closing stretch with no idling

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("Run covered %0d instructions, %0d results checked, %0d prints, %0d errors",
             n_sent, n_checked, n_prints, n_errors);
    $display("Status mix: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, skipped %0d",
             status_cnt[0], status_cnt[1], status_cnt[2], status_cnt[3], status_cnt[4]);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
